// ===== src/adl_pkg.sv =====
`default_nettype none

package adl_pkg;

    // Default number of entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Adler-32 modulus (largest prime below 2^16), its double and the modulus less one, used in reductions.
    localparam logic [16:0] ADL_MOD      = 17'd65521;
    localparam logic [17:0] ADL_MOD_X2   = 18'd131042;
    localparam logic [16:0] ADL_MOD_LESS = 17'd65520;

    // Input mode codes as they appear on the mode field.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ABSORB = 2'd1;
    localparam logic [1:0] MODE_MERGE  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ABSORB,
        OP_MERGE
    } op_t;

    // One classified operation as it waits in the queue. For a load, arg_a and
    // arg_b are the reduced seed halves; for a merge they are the reduced
    // right-hand halves and seg_len is the segment length modulo 65521.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [15:0] seg_len;
    } q_entry_t;

    // Reduces a value known to be below twice the modulus.
    function automatic logic [15:0] mod_once(input logic [16:0] x);
        logic [16:0] d;
        d = x - ADL_MOD;
        return (x >= ADL_MOD) ? d[15:0] : x[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/adl_front.sv =====
`default_nettype none

module adl_front
    import adl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [31:0] s_value,
    input  wire logic [31:0] s_segment_length,
    input  wire logic        s_last,
    output logic             entry_valid,
    input  wire logic        entry_ready,
    output q_entry_t         entry
);

    // The front register holds the length after its first fold:
    // len = hi * 2^16 + lo, and 2^16 is 15 modulo 65521.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [19:0] len_fold;
    } front_stage_t;

    logic         stage_valid_reg;
    logic         stage_valid_next;
    front_stage_t stage_reg;
    front_stage_t stage_next;
    logic         keep;
    logic         accept;
    logic [16:0]  len_fold2;

    assign s_ready = !stage_valid_reg || entry_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        keep            = 1'b1;
        stage_next.op   = OP_LOAD;
        unique case (s_mode)
            MODE_LOAD:   stage_next.op = OP_LOAD;
            MODE_ABSORB: stage_next.op = OP_ABSORB;
            MODE_MERGE:  stage_next.op = OP_MERGE;
            default:     keep = 1'b0;
        endcase
        stage_next.data_byte = s_data_byte;
        stage_next.last      = s_last;
        stage_next.arg_a     = mod_once({1'b0, s_value[15:0]});
        stage_next.arg_b     = mod_once({1'b0, s_value[31:16]});
        stage_next.len_fold  = {s_segment_length[31:16], 4'b0000}
                             - 20'(s_segment_length[31:16])
                             + 20'(s_segment_length[15:0]);
    end

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = keep;
        end else if (entry_ready) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    // Second fold brings the length below twice the modulus.
    assign len_fold2 = 17'({stage_reg.len_fold[19:16], 4'b0000})
                     - 17'(stage_reg.len_fold[19:16])
                     + 17'(stage_reg.len_fold[15:0]);

    assign entry_valid       = stage_valid_reg;
    assign entry.op          = stage_reg.op;
    assign entry.data_byte   = stage_reg.data_byte;
    assign entry.last        = stage_reg.last;
    assign entry.arg_a       = stage_reg.arg_a;
    assign entry.arg_b       = stage_reg.arg_b;
    assign entry.seg_len     = mod_once(len_fold2);

endmodule

`default_nettype wire

// ===== src/adl_queue.sv =====
`default_nettype none

module adl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/adl_back.sv =====
`default_nettype none

module adl_back
    import adl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      q_valid,
    output logic           q_ready,
    input  wire q_entry_t  q_entry,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [31:0]    m_checksum
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FOLD,
        PH_REDUCE,
        PH_FINISH
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] sum_low_reg;
    logic [15:0] sum_low_next;
    logic [15:0] sum_high_reg;
    logic [15:0] sum_high_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_checksum_reg;
    logic [31:0] m_checksum_next;
    logic [31:0] product_reg;
    logic [31:0] product_next;
    logic [19:0] fold_reg;
    logic [19:0] fold_next;
    logic [15:0] pm_reg;
    logic [15:0] pm_next;
    logic [15:0] ra_reg;
    logic [15:0] ra_next;
    logic [15:0] rb_reg;
    logic [15:0] rb_next;

    logic        out_free;
    logic        needs_out;
    logic [15:0] absorb_low;
    logic [15:0] absorb_high;
    logic [15:0] base;
    logic [16:0] fold2;
    logic [17:0] hi_sum;
    logic [17:0] hi_diff1;
    logic [17:0] hi_diff2;
    logic [15:0] merge_high;
    logic [16:0] lo_sum;
    logic [16:0] lo_dec;
    logic [15:0] merge_low;

    assign out_free  = !m_valid_reg || m_ready;
    assign needs_out = (q_entry.op == OP_MERGE) || ((q_entry.op == OP_ABSORB) && q_entry.last);
    assign q_ready   = (phase_reg == PH_IDLE) && (!needs_out || out_free);

    // Absorb path: low sum first, then the high sum takes the new low sum.
    assign absorb_low  = mod_once(17'(sum_low_reg) + 17'(q_entry.data_byte));
    assign absorb_high = mod_once(17'(sum_high_reg) + 17'(absorb_low));

    // Merge path. base is (sum_low - 1) modulo 65521.
    assign base  = (sum_low_reg == '0) ? ADL_MOD_LESS[15:0] : sum_low_reg - 1'b1;
    assign fold2 = 17'({fold_reg[19:16], 4'b0000}) - 17'(fold_reg[19:16])
                 + 17'(fold_reg[15:0]);

    assign hi_sum     = 18'(sum_high_reg) + 18'(rb_reg) + 18'(pm_reg);
    assign hi_diff1   = hi_sum - 18'(ADL_MOD);
    assign hi_diff2   = hi_sum - ADL_MOD_X2;
    assign merge_high = (hi_sum >= ADL_MOD_X2)     ? hi_diff2[15:0] :
                        (hi_sum >= 18'(ADL_MOD))   ? hi_diff1[15:0] : hi_sum[15:0];

    assign lo_sum    = 17'(sum_low_reg) + 17'(ra_reg);
    assign lo_dec    = (lo_sum == '0) ? ADL_MOD_LESS : lo_sum - 1'b1;
    assign merge_low = mod_once(lo_dec);

    always_comb begin
        phase_next      = phase_reg;
        sum_low_next    = sum_low_reg;
        sum_high_next   = sum_high_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_checksum_next = m_checksum_reg;
        product_next    = product_reg;
        fold_next       = fold_reg;
        pm_next         = pm_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (q_valid && q_ready) begin
                    unique case (q_entry.op)
                        OP_LOAD: begin
                            sum_low_next  = q_entry.arg_a;
                            sum_high_next = q_entry.arg_b;
                        end
                        OP_ABSORB: begin
                            sum_low_next  = absorb_low;
                            sum_high_next = absorb_high;
                            if (q_entry.last) begin
                                m_valid_next    = 1'b1;
                                m_checksum_next = {absorb_high, absorb_low};
                            end
                        end
                        OP_MERGE: begin
                            product_next = 32'(q_entry.seg_len) * 32'(base);
                            ra_next      = q_entry.arg_a;
                            rb_next      = q_entry.arg_b;
                            phase_next   = PH_FOLD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_FOLD: begin
                fold_next  = {product_reg[31:16], 4'b0000} - 20'(product_reg[31:16])
                           + 20'(product_reg[15:0]);
                phase_next = PH_REDUCE;
            end
            PH_REDUCE: begin
                pm_next    = mod_once(fold2);
                phase_next = PH_FINISH;
            end
            PH_FINISH: begin
                sum_low_next    = merge_low;
                sum_high_next   = merge_high;
                m_valid_next    = 1'b1;
                m_checksum_next = {merge_high, merge_low};
                phase_next      = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            sum_low_reg  <= 16'd1;
            sum_high_reg <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            sum_low_reg    <= sum_low_next;
            sum_high_reg   <= sum_high_next;
            m_valid_reg    <= m_valid_next;
            m_checksum_reg <= m_checksum_next;
            product_reg    <= product_next;
            fold_reg       <= fold_next;
            pm_reg         <= pm_next;
            ra_reg         <= ra_next;
            rb_reg         <= rb_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_checksum = m_checksum_reg;

`ifndef NO_ASSERTIONS
    // No queue entry is taken while a merge is in flight.
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> !q_ready)
        else $error("queue popped during merge");

    // The last merge step always presents a result.
    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FINISH |=> m_valid_reg)
        else $error("merge finished without a result");

    // The running sums hold still while the product is being reduced.
    a_sums_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FOLD |=> $stable(sum_low_reg) && $stable(sum_high_reg))
        else $error("running sums changed during merge");

    // Both running sums stay reduced.
    a_sums_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (17'(sum_low_reg) < ADL_MOD) && (17'(sum_high_reg) < ADL_MOD))
        else $error("running sum not reduced");
`endif

endmodule

`default_nettype wire

// ===== src/adler32_checksum_with_merge.sv =====
// Streaming Adler-32 checksum with seed loading and merge of a right-hand checksum.
// Input channel (s_valid/s_ready): one beat carries s_mode, s_data_byte, s_value,
// s_segment_length and s_last. Mode 0 loads a seed, mode 1 absorbs one byte and
// mode 2 merges s_value, the checksum of s_segment_length following bytes. Mode 3
// beats are accepted and dropped.
// Result channel (m_valid/m_ready): one beat with m_checksum (high half b, low
// half a) after each absorbed byte marked s_last and after every merge.
// Loads and absorbs run at one beat per cycle while the execution unit is idle
// and, for a beat that needs the output, the result register is free. A merge
// occupies the execution unit (multiply, two folds of the product modulo 65521,
// final add); no queued beat is taken until it is done. A last-byte result passes
// the front register, queue and output register; a merge also passes its steps.
// A front register and a short queue decouple the input from the execution unit,
// so input beats keep being accepted while a result waits at the output, until the queue fills.
// When the receiver stalls, the result register holds its beat; loads and plain absorbs still
// execute until a beat that needs the output heads the queue, and that beat waits there.
// Reset (aresetn low, synchronous) empties the front and queue, drops any pending
// result and sets the running checksum to 1 (a = 1, b = 0).
`default_nettype none

module adler32_checksum_with_merge
    import adl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [31:0] s_value,
    input  wire logic [31:0] s_segment_length,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_checksum
);

    // Front to queue.
    logic     front_valid;
    logic     front_ready;
    q_entry_t front_entry;

    // Queue to execution unit.
    logic     q_valid;
    logic     q_ready;
    q_entry_t q_entry;

    // The front reduces the seed or right-hand halves and folds the segment
    // length modulo 65521, so the back only sees narrow operands.
    adl_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .s_value          (s_value),
        .s_segment_length (s_segment_length),
        .s_last           (s_last),
        .entry_valid      (front_valid),
        .entry_ready      (front_ready),
        .entry            (front_entry)
    );

    adl_queue #(
        .WIDTH ($bits(q_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_entry)
    );

    // The back holds the running sums and the output register.
    adl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_entry    (q_entry),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_checksum (m_checksum)
    );

endmodule

`default_nettype wire

// ===== dv/adler32_checksum_with_merge_tb.sv =====
`default_nettype none

// Self-checking bench for the streaming Adler-32 block with seed load and merge.
// A behavioral model of the two running sums is updated on every accepted input
// beat, and it queues the checksum that each result beat must carry. A monitor
// on the result channel compares every result beat with the oldest queued value.
module adler32_checksum_with_merge_tb;
    import adl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 500_000;

    // The fourth mode code has no meaning; the block must drop such beats.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_data_byte;
    logic [31:0] s_value;
    logic [31:0] s_segment_length;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_checksum;

    // Model state: the low sum (a) and the high sum (b), both kept reduced.
    logic [15:0] model_sum_a;
    logic [15:0] model_sum_b;

    // Checksums that the block still owes on its result channel, oldest first.
    logic [31:0] pending_sums[$];
    logic [31:0] oldest_sum;

    int mismatches;
    int sums_matched;
    int seeds_loaded;
    int bytes_absorbed;
    int merges_sent;
    int beats_dropped;

    // Set by the stimulus to switch off random idling on both channels.
    bit no_idle;

    // The stimulus raises stalls_asked to request one long hold of m_ready;
    // the receiver process counts the hold out and then raises stalls_served.
    int stalls_asked;
    int stalls_served;

    adler32_checksum_with_merge uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .s_value          (s_value),
        .s_segment_length (s_segment_length),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_checksum       (m_checksum)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard ceiling on the run time. A correct run needs only a few percent of it,
    // even with every item a merge and every stall at its longest.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d checksums still outstanding.", pending_sums.size());
        $display("adler32_checksum_with_merge_tb NOT OK");
        $finish;
    end

    // Counts a failure and prints the first few in full; later ones are only counted.
    function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s: expected %08h, got %08h", $time, what, want, got);
        end
    endfunction

    // Advances the model by one accepted beat and queues the checksum it must emit, if any.
    // The merge formula uses the low sum from before the beat for the high half,
    // so the high half is computed first.
    task automatic advance_checksum(input logic [1:0] mode, input logic [7:0] data_byte,
                                    input logic [31:0] value, input logic [31:0] seg_len,
                                    input logic last);
        longint unsigned right_a;
        longint unsigned right_b;
        longint unsigned seg_mod;
        longint unsigned shifted_a;
        longint unsigned next_a;
        longint unsigned next_b;
        right_a = value[15:0];
        right_b = value[31:16];
        case (mode)
            MODE_LOAD: begin
                model_sum_a = 16'(right_a % ADL_MOD);
                model_sum_b = 16'(right_b % ADL_MOD);
            end
            MODE_ABSORB: begin
                next_a = (model_sum_a + data_byte) % ADL_MOD;
                next_b = (model_sum_b + next_a) % ADL_MOD;
                model_sum_a = 16'(next_a);
                model_sum_b = 16'(next_b);
                if (last) begin
                    pending_sums.push_back({model_sum_b, model_sum_a});
                end
            end
            MODE_MERGE: begin
                seg_mod = seg_len % ADL_MOD;
                shifted_a = (model_sum_a + ADL_MOD_LESS) % ADL_MOD;
                next_b = (model_sum_b + right_b + seg_mod * shifted_a) % ADL_MOD;
                next_a = (model_sum_a + ADL_MOD_LESS + right_a) % ADL_MOD;
                model_sum_a = 16'(next_a);
                model_sum_b = 16'(next_b);
                pending_sums.push_back({model_sum_b, model_sum_a});
            end
            default: begin
            end
        endcase
    endtask

    // Offers one input beat and returns at the falling edge after it was accepted.
    // It is entered at a falling edge; before offering it may idle at random.
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] data_byte,
                             input logic [31:0] value, input logic [31:0] seg_len,
                             input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_data_byte      <= data_byte;
        s_value          <= value;
        s_segment_length <= seg_len;
        s_last           <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        advance_checksum(mode, data_byte, value, seg_len, last);
        case (mode)
            MODE_LOAD:   seeds_loaded++;
            MODE_ABSORB: bytes_absorbed++;
            MODE_MERGE:  merges_sent++;
            default:     beats_dropped++;
        endcase
        @(negedge aclk);
    endtask

    // Receiver: m_ready changes only at falling edges. Normally it drops at
    // random; on request it holds off for a long, counted stretch.
    initial begin : receiver
        int hold_count;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stalls_served != stalls_asked) begin
                m_ready <= 1'b0;
                for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(negedge aclk);
                end
                stalls_served++;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Result monitor: every beat taken on the result channel must match the
    // oldest checksum that the model has queued.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                note_failure("result beat with no checksum pending", 32'h0, m_checksum);
            end else begin
                oldest_sum = pending_sums.pop_front();
                if (m_checksum !== oldest_sum) begin
                    note_failure("checksum mismatch", oldest_sum, m_checksum);
                end else begin
                    sums_matched++;
                end
            end
        end
    end

    // Right after reset the running checksum must be the standard start of 1.
    task automatic test_start_value();
        send_beat(MODE_ABSORB, 8'h00, 32'h0, 32'h0, 1'b1);
        send_beat(MODE_ABSORB, 8'h61, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_beat(MODE_ABSORB, 8'hff, 32'h0, 32'h0, 1'b1);
    endtask

    // Seed halves at and above the modulus must come out reduced, and the
    // largest legal sums must wrap correctly on the next byte.
    task automatic test_seed_reduction();
        send_beat(MODE_LOAD, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_beat(MODE_ABSORB, 8'h00, 32'h0, 32'h0, 1'b1);
        send_beat(MODE_LOAD, 8'h00, 32'hfff0_fff0, 32'h0, 1'b0);
        send_beat(MODE_ABSORB, 8'hff, 32'h0, 32'h0, 1'b1);
        send_beat(MODE_LOAD, 8'h5a, 32'hfff1_fff1, 32'h0, 1'b0);
        send_beat(MODE_ABSORB, 8'h00, 32'h0, 32'h0, 1'b1);
        send_beat(MODE_LOAD, 8'h00, 32'h0000_0000, 32'h0, 1'b0);
        send_beat(MODE_ABSORB, 8'hff, 32'h0, 32'h0, 1'b1);
    endtask

    // Merges with empty and maximal segments, a segment length that is a
    // multiple of the modulus, and right halves above the modulus. The last
    // flag means nothing here: every merge must emit.
    task automatic test_merge_corners();
        send_beat(MODE_LOAD, 8'h00, 32'h0000_0001, 32'h0, 1'b0);
        send_beat(MODE_MERGE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_beat(MODE_MERGE, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_beat(MODE_MERGE, 8'h00, 32'h0001_0001, 32'd65521, 1'b0);
        send_beat(MODE_LOAD, 8'h00, 32'h0000_0000, 32'h0, 1'b0);
        send_beat(MODE_MERGE, 8'h00, 32'hfff0_fff0, 32'd1, 1'b1);
    endtask

    // Beats with the spare mode code must leave the sums alone and emit nothing,
    // even with the last flag set.
    task automatic test_ignored_beats();
        send_beat(MODE_SPARE, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_beat(MODE_ABSORB, 8'h01, 32'h0, 32'h0, 1'b1);
        send_beat(MODE_SPARE, 8'h00, 32'h0, 32'h0, 1'b0);
    endtask

    // The receiver holds off for a long stretch while beats that each produce a
    // result keep coming, so the internal queue fills and s_ready must drop.
    task automatic test_output_stall();
        stalls_asked++;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 2) begin
                send_beat(MODE_MERGE, 8'($urandom), $urandom, $urandom_range(0, 64),
                          1'($urandom));
            end else begin
                send_beat(MODE_ABSORB, 8'($urandom), $urandom, $urandom, 1'b1);
            end
        end
    endtask

    // Random traffic, mostly well-formed messages: an optional seed, a run of
    // bytes closed by last, sometimes a merge. About a fifth is pure noise with
    // every field random. Dropped beats do not count toward the target. A middle
    // stretch runs with no idling on either side.
    task automatic test_random_streams(input int target);
        int counted;
        int run_len;
        int pick;
        logic [1:0] noise_mode;
        logic [31:0] seg_len;
        counted = 0;
        while (counted < target) begin
            no_idle = (counted >= target / 3) && (counted < target / 2);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    send_beat(MODE_LOAD, 8'($urandom), 32'd1, $urandom, 1'($urandom));
                    counted++;
                end else if (pick < 7) begin
                    send_beat(MODE_LOAD, 8'($urandom), $urandom, $urandom, 1'($urandom));
                    counted++;
                end
                run_len = $urandom_range(1, 16);
                for (int i = 0; i < run_len; i++) begin
                    send_beat(MODE_ABSORB, 8'($urandom), $urandom, $urandom,
                              i == run_len - 1);
                end
                counted += run_len;
                if ($urandom_range(0, 4) == 0) begin
                    seg_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 300) : $urandom;
                    send_beat(MODE_MERGE, 8'($urandom), $urandom, seg_len, 1'($urandom));
                    counted++;
                end
            end else begin
                noise_mode = 2'($urandom_range(0, 3));
                send_beat(noise_mode, 8'($urandom), $urandom, $urandom, 1'($urandom));
                if (noise_mode != MODE_SPARE) begin
                    counted++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        // Every input is at a known value from time zero, and reset is
        // applied exactly once.
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_mode           = MODE_LOAD;
        s_data_byte      = 8'h00;
        s_value          = 32'h0;
        s_segment_length = 32'h0;
        s_last           = 1'b0;
        no_idle          = 1'b0;
        stalls_asked     = 0;
        stalls_served    = 0;
        mismatches       = 0;
        sums_matched     = 0;
        seeds_loaded     = 0;
        bytes_absorbed   = 0;
        merges_sent      = 0;
        beats_dropped    = 0;
        model_sum_a      = 16'd1;
        model_sum_b      = 16'd0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_start_value();
        test_seed_reduction();
        test_merge_corners();
        test_ignored_beats();
        test_output_stall();
        test_random_streams(RANDOM_ITEMS);

        // Stop offering input, wait for every owed checksum, then give the
        // block a few more cycles to show any stray result beat.
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d seeds, %0d bytes, %0d merges and %0d spare-mode beats.",
                 seeds_loaded, bytes_absorbed, merges_sent, beats_dropped);
        $display("Matched %0d checksums across %0d long output stall(s); %0d failure(s).",
                 sums_matched, stalls_served, mismatches);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("adler32_checksum_with_merge_tb OK");
        end else begin
            $display("adler32_checksum_with_merge_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
